// ----- sv/jlvr_pkg.sv -----
// ----------------------------------------------------------------------------
// jlvr_pkg
// shared types and constants of the jerk limited velocity reference
// ----------------------------------------------------------------------------
package jlvr_pkg;

  localparam int DATA_W  = 32;
  localparam int FRAC_W  = 16;
  localparam int CFG_W   = 31;
  localparam int PER_W   = 16;
  localparam int ADDR_W  = 5;
  localparam int VNZ_W   = 36;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_JERK_MAX      = 3'd0,
    REG_STOP_DISTANCE = 3'd1,
    REG_SPEED_MAX     = 3'd2,
    REG_SPEED_MIN     = 3'd3,
    REG_STEP_PERIOD   = 3'd4
  } cfg_idx_t;

  // per-word flags and cruise-side result traveling down the pipe
  typedef struct packed {
    logic                     zone;
    logic                     neg;
    logic                     zero;
    logic                     dt_zero;
    logic signed [VNZ_W-1:0]  v_nz;
  } side_t;

endpackage

// ----- sv/jerk_limited_velocity_reference.sv -----
// ----------------------------------------------------------------------------
// jerk_limited_velocity_reference
// pipelined septic-smoothstep velocity reference with jerk limited run-up
// ----------------------------------------------------------------------------
// Takes one word per cycle unless the output stalls, and returns one word per
// word. The pipe is one input stage, the 16-stage restoring divider that
// forms x = |distance| / stop_distance (one quotient bit per stage), then four
// stages of the smoothstep polynomial (one multiplier layer each) and one output
// stage. The whole pipe advances together: it moves whenever the output register
// is empty or being taken, so words stream back to back. Users write registers
// over the APB port only while no word is in flight; the block does not enforce it.
module jerk_limited_velocity_reference (
  input  logic                       clk,
  input  logic                       rst,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [jlvr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // input stream
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [95:0]                s_tdata,  // distance_left, speed_now, accel_now
  // output stream
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [31:0]                m_tdata,  // speed_ref
  output logic                       m_tuser   // in_stop_zone
);
  import jlvr_pkg::*;

  localparam int NS   = 21;             // stages before the output register
  localparam int DIVN = FRAC_W;         // divider stages

  // configuration registers
  logic [CFG_W-1:0] jerk_max, stop_distance, speed_max, speed_min;
  logic [PER_W-1:0] step_period;
  logic [31:0]      jstep;              // jerk_max * dt, Q16.16
  logic             wr_en;
  logic [46:0]      jstep_prod;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      jerk_max      <= '0;
      stop_distance <= '0;
      speed_max     <= '0;
      speed_min     <= '0;
      step_period   <= '0;
      jstep         <= '0;
    end else begin
      jstep <= {1'b0, jstep_prod[46:FRAC_W]};
      if (wr_en) begin
        unique case (paddr[4:2])
          REG_JERK_MAX:      jerk_max      <= pwdata[CFG_W-1:0];
          REG_STOP_DISTANCE: stop_distance <= pwdata[CFG_W-1:0];
          REG_SPEED_MAX:     speed_max     <= pwdata[CFG_W-1:0];
          REG_SPEED_MIN:     speed_min     <= pwdata[CFG_W-1:0];
          REG_STEP_PERIOD:   step_period   <= pwdata[PER_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign jstep_prod = 47'(jerk_max) * 47'(step_period);

  always_comb begin
    unique case (paddr[4:2])
      REG_JERK_MAX:      prdata = {1'b0, jerk_max};
      REG_STOP_DISTANCE: prdata = {1'b0, stop_distance};
      REG_SPEED_MAX:     prdata = {1'b0, speed_max};
      REG_SPEED_MIN:     prdata = {1'b0, speed_min};
      REG_STEP_PERIOD:   prdata = {16'd0, step_period};
      default:           prdata = '0;
    endcase
  end

  // truncation toward zero of a signed Q.16 product
  function automatic logic signed [63:0] trunc_q(input logic signed [63:0] p);
    logic signed [63:0] adj;
    adj = p + (p[63] ? 64'sd65535 : 64'sd0);
    return adj >>> FRAC_W;
  endfunction

  // global advance: the pipe moves when the output slot frees up
  logic en;
  logic out_vld;
  assign en       = !out_vld || m_tready;
  assign s_tready = en;

  logic  vld  [0:NS-1];
  side_t side [0:NS-1];

  // stage 0: magnitudes, zone decision, divider seed
  logic signed [31:0] in_d, in_v, in_a;
  logic [31:0]        abs_d_in;
  logic               zone_in, eq_in;
  assign in_d     = s_tdata[31:0];
  assign in_v     = s_tdata[63:32];
  assign in_a     = s_tdata[95:64];
  assign abs_d_in = in_d[31] ? 32'(-in_d) : 32'(in_d);
  assign zone_in  = abs_d_in <= {1'b0, stop_distance};
  assign eq_in    = (abs_d_in == {1'b0, stop_distance}) && (stop_distance != '0);

  logic [31:0]      av0, aa0;
  logic [CFG_W-1:0] rem [0:DIVN];
  logic [DIVN-1:0]  quo [0:DIVN];
  logic             eqx [0:DIVN];

  // cruise side, stages 1 and 2
  logic [48:0]        pa1;
  logic signed [50:0] pe1;
  logic [31:0]        av1;
  logic               slow1, ease1;

  // polynomial stages
  logic [16:0]        x17;
  logic [33:0]        mx2;
  logic [39:0]        mh0;
  logic [33:0]        mx4;
  logic signed [42:0] mh1;
  logic signed [44:0] ms;
  logic [47:0]        mv;

  logic [16:0]        x_div, x2, x4, s_cl;
  logic [22:0]        h0;
  logic signed [24:0] h1;
  logic signed [26:0] h2;
  logic signed [28:0] s_raw;
  logic signed [VNZ_W-1:0] v_nz2;
  side_t              side2_next;

  assign x_div = eqx[DIVN] ? 17'h10000 : {1'b0, quo[DIVN]};
  assign h0    = 23'(70 * 65536) - 23'(x_div) * 23'd20;
  assign x2    = mx2[32:16];
  assign h1    = $signed({2'b00, mh0[38:16]}) - 25'sd5505024;   // minus 84.0
  assign x4    = mx4[32:16];
  assign h2    = 27'(trunc_q(64'(mh1))) + 27'sd2293760;          // plus 35.0
  assign s_raw = 29'(trunc_q(64'(ms)));
  assign s_cl  = s_raw[28] ? 17'd0 : (s_raw > 29'sd65536) ? 17'h10000 : s_raw[16:0];

  always_comb begin
    if (slow1)
      v_nz2 = $signed({4'b0, av1}) + $signed({3'b0, pa1[48:16]});
    else if (ease1)
      v_nz2 = $signed({4'b0, av1}) + VNZ_W'(trunc_q(64'(pe1)));
    else
      v_nz2 = $signed({5'b0, speed_max});
  end

  // stage 2 flags with the cruise-side speed filled in
  always_comb begin
    side2_next      = side[1];
    side2_next.v_nz = v_nz2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NS; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= s_tvalid;
      for (int i = 1; i < NS; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 0
      side[0].zone    <= zone_in;
      side[0].neg     <= in_d[31];
      side[0].zero    <= (in_d == '0);
      side[0].dt_zero <= (step_period == '0);
      side[0].v_nz    <= '0;
      av0    <= in_v[31] ? 32'(-in_v) : 32'(in_v);
      aa0    <= in_a[31] ? 32'(-in_a) : 32'(in_a);
      rem[0] <= (zone_in && !eq_in) ? abs_d_in[CFG_W-1:0] : '0;
      quo[0] <= '0;
      eqx[0] <= eq_in;
      for (int i = 1; i < NS; i++) side[i] <= (i == 2) ? side2_next : side[i-1];
      // divider: one quotient bit per stage
      for (int i = 1; i <= DIVN; i++) begin
        if ({rem[i-1], 1'b0} >= {1'b0, stop_distance}) begin
          rem[i] <= CFG_W'({rem[i-1], 1'b0} - {1'b0, stop_distance});
          quo[i] <= {quo[i-1][DIVN-2:0], 1'b1};
        end else begin
          rem[i] <= CFG_W'({rem[i-1], 1'b0});
          quo[i] <= {quo[i-1][DIVN-2:0], 1'b0};
        end
        eqx[i] <= eqx[i-1];
      end
      // cruise side: products, then the chosen speed
      pa1   <= 49'(({1'b0, aa0} + {1'b0, jstep})) * 49'(step_period);
      pe1   <= 51'($signed({2'b0, aa0}) - $signed({2'b0, jstep}))
               * 51'($signed({1'b0, step_period}));
      av1   <= av0;
      slow1 <= {av0, 1'b0} < {2'b0, speed_max};
      ease1 <= (37'(jstep) * 37'd20) < (37'(aa0) * 37'd21);
      // septic smoothstep
      x17 <= x_div;
      mx2 <= 34'(x_div) * 34'(x_div);
      mh0 <= 40'(h0) * 40'(x_div);
      mx4 <= 34'(x2) * 34'(x2);
      mh1 <= 43'(h1) * 43'($signed({1'b0, x17}));
      ms  <= 45'(h2) * 45'($signed({1'b0, x4}));
      mv  <= 48'(speed_max) * 48'(s_cl);
    end
  end

  // output stage: pick branch, clamp, apply sign
  logic [CFG_W-1:0]        vmin_e;
  logic signed [VNZ_W-1:0] v_sel;
  logic [CFG_W-1:0]        mag;
  logic [31:0]             ref_out;
  side_t                   sl;

  assign sl     = side[NS-1];
  assign vmin_e = (speed_min > speed_max) ? speed_max : speed_min;
  assign v_sel  = sl.zone ? $signed({4'b0, mv[47:16]}) : sl.v_nz;

  always_comb begin
    if (v_sel < $signed({5'b0, vmin_e}))
      mag = vmin_e;
    else if (v_sel > $signed({5'b0, speed_max}))
      mag = speed_max;
    else
      mag = v_sel[CFG_W-1:0];
    if (sl.dt_zero || sl.zero)
      ref_out = '0;
    else if (sl.neg)
      ref_out = 32'(-$signed({1'b0, mag}));
    else
      ref_out = {1'b0, mag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= vld[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= ref_out;
      m_tuser <= sl.zone && !sl.dt_zero;
    end
  end

  assign m_tvalid = out_vld;

  // speed reference never leaves the +-speed_max band
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata) <= $signed({1'b0, speed_max}) &&
                  $signed(m_tdata) >= -$signed({1'b0, speed_max})))
    else $error("speed reference outside speed_max band");

  // a zero period gives a zero word with the stop-zone flag clear
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && step_period == '0) |-> (m_tdata == '0 && !m_tuser))
    else $error("nonzero output with zero period");

  // a stalled output slot freezes the pipe
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata) && $stable(vld[0]))
    else $error("pipe moved during stall");

endmodule
